### src/htsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsg_pkg: shared types and constants for the hash table set/get unit
// Beat layouts, table entry layout, status codes and sizing constants.
// ----------------------------------------------------------------------------
package htsg_pkg;

  localparam int CAPACITY      = 256;
  localparam int MAX_KEY_BYTES = 8;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int FREE_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(CAPACITY - 1);

  // set refused when free * 1000 < 333 * CAPACITY, i.e. free < ceil(333*CAP/1000)
  localparam int FULL_LIMIT = (333 * CAPACITY + 999) / 1000;

  // modulo (CAPACITY-1) by folding IDX_W-bit chunks
  localparam int MOD_CHUNKS = (64 + IDX_W - 1) / IDX_W;
  localparam int SUM_W      = IDX_W + $clog2(MOD_CHUNKS) + 1;
  localparam int MOD_FOLDS  = 4;

  localparam logic [63:0] HASH_SEED = 64'd5381;

  localparam logic FUNC_SET = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic        func;
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [63:0] value;
    logic [3:0]  value_len;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_value;
    logic [3:0]  found_len;
  } out_beat_t;

  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [63:0] value;
    logic [3:0]  value_len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        start;
    logic [63:0] key;
    logic [3:0]  key_len;
  } hash_req_t;

  typedef struct packed {
    logic             done;
    logic [63:0]      h;
    logic [IDX_W-1:0] idx;
  } hash_res_t;

  // ones in the low n bytes
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

### src/htsg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsg_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on contents.
// ----------------------------------------------------------------------------
module htsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/htsg_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsg_hash: iterative djb2 hash and home-slot index
// One key byte per cycle, then a reduce step modulo CAPACITY-1 in H_FOLD.
// ----------------------------------------------------------------------------
module htsg_hash (
  input  logic                clk,
  input  logic                rst_n,
  input  htsg_pkg::hash_req_t req,
  output htsg_pkg::hash_res_t res
);

  typedef enum logic [1:0] {H_IDLE, H_RUN, H_FOLD} hstate_t;

  hstate_t                      state_r;
  logic [63:0]                  h_r;
  logic [63:0]                  key_sh_r;
  logic [3:0]                   left_r;
  logic                         done_r;
  logic [63:0]                  res_h_r;
  logic [htsg_pkg::IDX_W-1:0]   res_idx_r;
  logic [htsg_pkg::SUM_W-1:0]   fold;
  logic [htsg_pkg::IDX_W-1:0]   home_idx;

  // h mod (2^W - 1): sum of W-bit chunks, fold, one final subtract
  always_comb begin
    fold = '0;
    for (int c = 0; c < htsg_pkg::MOD_CHUNKS; c++) begin
      fold = fold + htsg_pkg::SUM_W'(htsg_pkg::IDX_W'(h_r >> (c * htsg_pkg::IDX_W)));
    end
    for (int f = 0; f < htsg_pkg::MOD_FOLDS; f++) begin
      fold = htsg_pkg::SUM_W'(fold[htsg_pkg::IDX_W-1:0]) + (fold >> htsg_pkg::IDX_W);
    end
    if (fold >= htsg_pkg::SUM_W'(htsg_pkg::IDX_MASK)) begin
      fold = fold - htsg_pkg::SUM_W'(htsg_pkg::IDX_MASK);
    end
    home_idx = fold[htsg_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        H_IDLE: begin
          if (req.start) begin
            h_r      <= htsg_pkg::HASH_SEED;
            key_sh_r <= req.key;
            left_r   <= req.key_len;
            state_r  <= H_RUN;
          end
        end
        H_RUN: begin
          h_r      <= (h_r << 5) + h_r + {56'd0, key_sh_r[7:0]};
          key_sh_r <= key_sh_r >> 8;
          left_r   <= left_r - 4'd1;
          if (left_r == 4'd1) state_r <= H_FOLD;
        end
        H_FOLD: begin
          res_h_r   <= h_r;
          res_idx_r <= home_idx;
          done_r    <= 1'b1;
          state_r   <= H_IDLE;
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.h    = res_h_r;
  assign res.idx  = res_idx_r;

endmodule

### src/hash_table_set_get_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_set_get_unit: open-addressing key/value table with djb2 hashing
// Set/get requests on 1..8 byte keys; one result beat per request beat.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                         | Beat
//  --------+-------------------------------+---------------------------------
//  in      | in_valid, in_stall, in_data   | func, key, key_len, value, value_len
//  out     | out_valid, out_stall, out_data| status, found_value, found_len
//
// Flow: one request at a time. A set refused for load goes from accept
//   straight to S_RESP. Otherwise the hash takes one key byte per cycle, then
//   the reduce step and the handoff, then one probed slot per cycle (table RAM
//   read, registered), then S_RESP loads the output register once it is free.
// The probe walk is bound by the single table RAM read port, one slot a cycle.
// Reset clears the valid bits (flip-flops) and sets the free-slot count to CAPACITY;
//   the table RAM itself is never cleared, entries are gated by valid.
// in_stall is high while a request is in flight. One result can wait in the
//   output register under out_stall while the next request runs; a second
//   result then waits in S_RESP and keeps in_stall high.
// ----------------------------------------------------------------------------
module hash_table_set_get_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  htsg_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output htsg_pkg::out_beat_t out_data
);

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_PROBE, S_RESP} state_t;

  state_t                      state_r;
  logic                        func_r;
  logic [63:0]                 key_r;
  logic [3:0]                  klen_r;
  logic [63:0]                 val_r;
  logic [3:0]                  vlen_r;
  logic [63:0]                 p_r;
  logic [htsg_pkg::IDX_W-1:0]  idx_r;
  logic [htsg_pkg::IDX_W-1:0]  probe_cnt_r;
  logic [htsg_pkg::FREE_W-1:0] free_r;
  logic [htsg_pkg::CAPACITY-1:0] valid_r;
  htsg_pkg::out_beat_t         pend_r;
  htsg_pkg::out_beat_t         out_r;
  logic                        out_valid_r;

  logic                        in_fire;
  logic [3:0]                  klen_c;
  logic [3:0]                  vlen_c;
  logic [63:0]                 key_c;
  logic [63:0]                 val_c;
  logic                        load_full;

  htsg_pkg::hash_req_t         hreq;
  htsg_pkg::hash_res_t         hres;

  logic                        ram_we;
  logic                        ram_re;
  logic [htsg_pkg::IDX_W-1:0]  ram_raddr;
  logic [htsg_pkg::ENTRY_W-1:0] ram_rdata;
  htsg_pkg::entry_t            rd_ent;
  htsg_pkg::entry_t            wr_ent;

  logic                        slot_used;
  logic                        key_hit;
  logic                        last_probe;
  logic [htsg_pkg::IDX_W-1:0]  idx_step;
  logic                        out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // operand clean-up: key length clamped to 1..MAX, value length to 0..8
  always_comb begin
    if (in_data.key_len == 4'd0) begin
      klen_c = 4'd1;
    end else if (in_data.key_len > 4'(htsg_pkg::MAX_KEY_BYTES)) begin
      klen_c = 4'(htsg_pkg::MAX_KEY_BYTES);
    end else begin
      klen_c = in_data.key_len;
    end
    vlen_c = (in_data.value_len > 4'd8) ? 4'd8 : in_data.value_len;
    key_c  = in_data.key & htsg_pkg::byte_mask(klen_c);
    val_c  = in_data.value & htsg_pkg::byte_mask(vlen_c);
  end

  assign load_full = (free_r < htsg_pkg::FREE_W'(htsg_pkg::FULL_LIMIT));

  assign hreq.start   = in_fire && !(in_data.func == htsg_pkg::FUNC_SET && load_full);
  assign hreq.key     = key_c;
  assign hreq.key_len = klen_c;

  htsg_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .res   (hres)
  );

  // probe decision on the slot whose data is on the RAM output
  assign rd_ent     = htsg_pkg::entry_t'(ram_rdata);
  assign slot_used  = valid_r[idx_r];
  assign key_hit    = slot_used && (rd_ent.key_len == klen_r) && (rd_ent.key == key_r);
  assign last_probe = (probe_cnt_r == htsg_pkg::IDX_MASK);
  assign idx_step   = idx_r + (idx_r << 2) + p_r[htsg_pkg::IDX_W-1:0]
                      + htsg_pkg::IDX_W'(1);

  // next read: home slot when the hash lands, next probe slot while walking
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_step;
    if (state_r == S_HASH && hres.done) begin
      ram_re    = 1'b1;
      ram_raddr = hres.idx;
    end else if (state_r == S_PROBE && slot_used && !key_hit && !last_probe) begin
      ram_re    = 1'b1;
      ram_raddr = idx_step;
    end
  end

  // a set writes the whole entry on insert and on replace (key unchanged)
  assign ram_we = (state_r == S_PROBE) && (func_r == htsg_pkg::FUNC_SET) &&
                  (!slot_used || key_hit);

  assign wr_ent.key       = key_r;
  assign wr_ent.key_len   = klen_r;
  assign wr_ent.value     = val_r;
  assign wr_ent.value_len = vlen_r;

  htsg_ram #(
    .WIDTH (htsg_pkg::ENTRY_W),
    .DEPTH (htsg_pkg::CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= htsg_pkg::FREE_W'(htsg_pkg::CAPACITY);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output register: refill from S_RESP, or drop once taken
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            func_r <= in_data.func;
            key_r  <= key_c;
            klen_r <= klen_c;
            val_r  <= val_c;
            vlen_r <= vlen_c;
            if (in_data.func == htsg_pkg::FUNC_SET && load_full) begin
              pend_r.status      <= htsg_pkg::ST_FULL;
              pend_r.found_value <= '0;
              pend_r.found_len   <= '0;
              state_r            <= S_RESP;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hres.done) begin
            idx_r       <= hres.idx;
            p_r         <= hres.h;
            probe_cnt_r <= '0;
            state_r     <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (!slot_used) begin
            pend_r.found_value <= '0;
            pend_r.found_len   <= '0;
            if (func_r == htsg_pkg::FUNC_SET) begin
              valid_r[idx_r] <= 1'b1;
              if (free_r != '0) free_r <= free_r - htsg_pkg::FREE_W'(1);
              pend_r.status <= htsg_pkg::ST_INSERTED;
            end else begin
              pend_r.status <= htsg_pkg::ST_NOT_FOUND;
            end
            state_r <= S_RESP;
          end else if (key_hit) begin
            if (func_r == htsg_pkg::FUNC_SET) begin
              pend_r.status      <= htsg_pkg::ST_REPLACED;
              pend_r.found_value <= '0;
              pend_r.found_len   <= '0;
            end else begin
              pend_r.status      <= htsg_pkg::ST_FOUND;
              pend_r.found_value <= rd_ent.value;
              pend_r.found_len   <= rd_ent.value_len;
            end
            state_r <= S_RESP;
          end else if (last_probe) begin
            // probe limit reached (CAPACITY probes): no match and no hole
            pend_r.status <= (func_r == htsg_pkg::FUNC_SET) ? htsg_pkg::ST_FULL
                                                            : htsg_pkg::ST_NOT_FOUND;
            pend_r.found_value <= '0;
            pend_r.found_len   <= '0;
            state_r <= S_RESP;
          end else begin
            idx_r       <= idx_step;
            p_r         <= p_r >> 5;
            probe_cnt_r <= probe_cnt_r + htsg_pkg::IDX_W'(1);
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_r   <= pend_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
